FILE: sv/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types, constants and helper functions for the FAT16 cluster chain
// engine: table geometry, operation and status codes, memory request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fcce_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 16;
    localparam int CFG_W       = 13;

    // The scan position can reach the smaller of the table depth and the
    // largest value the configuration register can hold.
    localparam int CFG_MAX  = (1 << CFG_W) - 1;
    localparam int SCAN_MAX = (TABLE_DEPTH < CFG_MAX) ? TABLE_DEPTH : CFG_MAX;
    localparam int SCAN_W   = $clog2(SCAN_MAX + 1);

    localparam logic [16:0]       DEPTH_17        = 17'(TABLE_DEPTH);
    localparam logic [CFG_W-1:0]  TOTAL_RESET     = CFG_W'(4096);
    localparam logic [DATA_W-1:0] END_OF_CHAIN    = 16'hFFFF;
    localparam logic [DATA_W-1:0] FIRST_RESERVED  = 16'hFFF7;
    localparam logic [DATA_W-1:0] FIRST_DATA      = 16'd2;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // One port of memory traffic: a write and a read may go out together.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } result_t;

    // Decision for one step of a chain release.
    typedef struct packed {
        logic    go;
        status_t status;
    } verdict_t;

    // True when a 16-bit cluster number addresses an entry of the table.
    function automatic logic in_table(input logic [DATA_W-1:0] idx);
        in_table = ({1'b0, idx} < DEPTH_17);
    endfunction

    // Decides whether the release walk frees the entry at idx, and which
    // status it ends with when it does not.
    function automatic verdict_t rel_verdict(input logic [DATA_W-1:0] idx,
                                             input logic [CFG_W-1:0]  freed,
                                             input logic [CFG_W-1:0]  total);
        verdict_t v;
        v.go     = 1'b0;
        v.status = ST_OK;
        if (idx < FIRST_DATA || idx >= FIRST_RESERVED) begin
            v.status = ST_OK;
        end
        else if (!in_table(idx)) begin
            v.status = ST_RANGE;
        end
        else if (freed >= total) begin
            v.status = ST_TOO_LONG;
        end
        else begin
            v.go = 1'b1;
        end
        rel_verdict = v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fat16_cluster_chain_engine_core.sv
// ----------------------------------------------------------------------------
// fat16_cluster_chain_engine_core
// FAT16 allocation table engine with read, write, allocate and release.
// ----------------------------------------------------------------------------
// The table lives in one dual-port RAM and is not cleared at reset: load every
// entry that will be used with write transactions first. The block takes one
// transaction at a time, and the result sits in an output register so the
// next transaction can be taken while it waits. Allocate reads one table
// entry per cycle from cluster 2 upward and, when the new cluster is linked
// from a previous one, writes that link after the scan; the number of entries
// examined is bounded by the smaller of total_clusters and the table depth,
// less two. Release frees one chain entry per cycle. A result that waits in
// the output register holds back the end of the next transaction, not its
// intake.
// ----------------------------------------------------------------------------
`default_nettype none

module fat16_cluster_chain_engine_core
    import fcce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [DATA_W-1:0]  cluster,
    input  wire logic [DATA_W-1:0]  entry_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DATA_W-1:0]       result_value,
    output logic [1:0]              status
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              slot_free;
    logic              done_valid;
    result_t           done_res;
    logic              out_valid_reg;
    logic [DATA_W-1:0] result_value_reg;
    status_t           status_reg;

    assign slot_free = !out_valid_reg || out_ready;

    fcce_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .cluster     (cluster),
        .entry_value (entry_value),
        .slot_free   (slot_free),
        .done_valid  (done_valid),
        .done_res    (done_res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    fcce_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid)
        begin
            result_value_reg <= done_res.value;
            status_reg       <= done_res.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

FILE: sv/fcce_ram.sv
// ----------------------------------------------------------------------------
// fcce_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. A read of the address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fcce_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/fcce_ctrl.sv
// ----------------------------------------------------------------------------
// fcce_ctrl
// Operation sequencer: decodes each transaction, drives reads and writes of
// the allocation table, runs the allocate scan and the release walk, and holds
// the cluster count register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcce_ctrl
    import fcce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          operation,
    input  wire logic [DATA_W-1:0]   cluster,
    input  wire logic [DATA_W-1:0]   entry_value,
    input  wire logic                slot_free,
    output logic                     done_valid,
    output result_t                  done_res,
    output mem_req_t                 mem_req,
    input  wire logic [DATA_W-1:0]   mem_rdata
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD_WAIT = 6'b000010,
        S_SCAN    = 6'b000100,
        S_LINK    = 6'b001000,
        S_REL     = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    total_reg;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic                link_reg, link_next;
    logic [SCAN_W-1:0]   issue_reg, issue_next;
    logic                chk_v_reg, chk_v_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [DATA_W-1:0]   idx_reg, idx_next;
    logic [CFG_W-1:0]    freed_reg, freed_next;
    logic [DATA_W-1:0]   res_val_reg, res_val_next;
    status_t             res_st_reg, res_st_next;
    logic                fwd_hit_reg;
    logic [DATA_W-1:0]   fwd_data_reg;

    logic [DATA_W-1:0]   rdata_eff;
    logic [SCAN_W-1:0]   scan_lim;
    logic [CFG_W-1:0]    freed_inc;
    verdict_t            v_start, v_step;
    logic                cl_in_table;
    logic                scan_hit;

    // Cluster count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            total_reg <= cfg_wdata;
        end
    end

    // A release frees an entry and reads its successor in the same cycle;
    // when both hit one entry, the freshly written value wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mem_req.wdata;
    end

    assign rdata_eff = fwd_hit_reg ? fwd_data_reg : mem_rdata;

    // Scan bound: the smaller of the configured count and the table depth.
    assign scan_lim = ({4'b0, total_reg} > DEPTH_17) ? SCAN_W'(DEPTH_17)
                                                      : SCAN_W'(total_reg);

    assign freed_inc   = freed_reg + CFG_W'(1);
    assign v_start     = rel_verdict(cluster, '0, total_reg);
    assign v_step      = rel_verdict(rdata_eff, freed_inc, total_reg);
    assign cl_in_table = in_table(cluster);
    assign scan_hit    = chk_v_reg && (rdata_eff == '0);

    assign in_ready   = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE) && slot_free;
    assign done_res   = '{value: res_val_reg, status: res_st_reg};

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        prev_next    = prev_reg;
        link_next    = link_reg;
        issue_next   = issue_reg;
        chk_v_next   = 1'b0;
        chk_idx_next = chk_idx_reg;
        idx_next     = idx_reg;
        freed_next   = freed_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    unique case (op_t'(operation))
                        OP_READ:
                        begin
                            if (cl_in_table)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = IDX_W'(cluster);
                                state_next    = S_RD_WAIT;
                            end
                            else
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (cl_in_table)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = IDX_W'(cluster);
                                mem_req.wdata = entry_value;
                            end
                            else
                            begin
                                res_st_next = ST_RANGE;
                            end
                            state_next = S_DONE;
                        end
                        OP_ALLOC:
                        begin
                            if (cluster >= FIRST_DATA && !cl_in_table)
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                prev_next  = IDX_W'(cluster);
                                link_next  = (cluster >= FIRST_DATA);
                                issue_next = SCAN_W'(2);
                                state_next = S_SCAN;
                            end
                        end
                        OP_RELEASE:
                        begin
                            idx_next   = cluster;
                            freed_next = '0;
                            if (v_start.go)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = IDX_W'(cluster);
                                state_next    = S_REL;
                            end
                            else
                            begin
                                res_st_next = v_start.status;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                res_val_next = rdata_eff;
                state_next   = S_DONE;
            end

            // One table read issued per cycle; its data is checked in the next cycle.
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = chk_idx_reg;
                    mem_req.wdata = END_OF_CHAIN;
                    res_val_next  = DATA_W'(chk_idx_reg);
                    res_st_next   = ST_OK;
                    state_next    = link_reg ? S_LINK : S_DONE;
                end
                else if (issue_reg < scan_lim)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(issue_reg);
                    chk_v_next    = 1'b1;
                    chk_idx_next  = IDX_W'(issue_reg);
                    issue_next    = issue_reg + SCAN_W'(1);
                end
                else
                begin
                    res_val_next = '0;
                    res_st_next  = ST_FULL;
                    state_next   = S_DONE;
                end
            end

            // Point the previous cluster at the new one.
            S_LINK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = prev_reg;
                mem_req.wdata = res_val_reg;
                state_next    = S_DONE;
            end

            // Free the current entry and fetch its successor in the same cycle.
            S_REL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(idx_reg);
                mem_req.wdata = '0;
                freed_next    = freed_inc;
                idx_next      = rdata_eff;
                if (v_step.go)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(rdata_eff);
                end
                else
                begin
                    res_val_next = DATA_W'(freed_inc);
                    res_st_next  = v_step.status;
                    state_next   = S_DONE;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chk_v_reg <= 1'b0;
            link_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_v_reg <= chk_v_next;
            link_reg  <= link_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge clk)
    begin
        prev_reg    <= prev_next;
        issue_reg   <= issue_next;
        chk_idx_reg <= chk_idx_next;
        idx_reg     <= idx_next;
        freed_reg   <= freed_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
    end

endmodule

`default_nettype wire

FILE: sv/fcce_checker.sv
// ----------------------------------------------------------------------------
// fcce_checker
// Port-level checks of the cluster chain engine, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fcce_checker
    import fcce_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] result_value,
    input wire logic [1:0]        status
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
        else $error("result changed or dropped while stalled");

    // One transaction at a time: intake closes after each accepted transaction.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is in flight");

    // A full table never reports a cluster number.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (result_value == '0))
        else $error("table-full result carries a nonzero cluster");

endmodule

bind fat16_cluster_chain_engine_core fcce_checker u_fcce_checker (.*);

`default_nettype wire
